@@ src/ldtu_pkg.sv @@
// Shared constants, types and the strength classifier for the device table.
package ldtu_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int MAC_W = 48;
  localparam int SIG_W = 8;
  localparam int TICK_W = 32;
  localparam int CLASS_W = 2;
  localparam int SLOT_OUT_W = 5;
  localparam int COUNT_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STRONG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODERATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEAK = 2'd2;

  localparam logic signed [SIG_W-1:0] STRONG_RESET = -8'sd50;
  localparam logic signed [SIG_W-1:0] MODERATE_RESET = -8'sd70;
  localparam logic signed [SIG_W-1:0] WEAK_RESET = -8'sd85;

  localparam logic [CLASS_W-1:0] CLASS_STRONG = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_MODERATE = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_WEAK = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_VERY_WEAK = 2'd3;

  typedef struct packed {
    logic capture;
    logic rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic commit;
  } ldtu_cmd_t;

  typedef struct packed {
    logic out_busy;
  } ldtu_status_t;

  function automatic logic [CLASS_W-1:0] classify(
    input logic signed [SIG_W-1:0] sig,
    input logic signed [SIG_W-1:0] strong_th,
    input logic signed [SIG_W-1:0] moderate_th,
    input logic signed [SIG_W-1:0] weak_th
  );
    logic [CLASS_W-1:0] cls;
    if (sig >= strong_th) begin
      cls = CLASS_STRONG;
    end else if (sig >= moderate_th) begin
      cls = CLASS_MODERATE;
    end else if (sig >= weak_th) begin
      cls = CLASS_WEAK;
    end else begin
      cls = CLASS_VERY_WEAK;
    end
    return cls;
  endfunction

endpackage

@@ src/ldtu_ctrl.sv @@
// Controller: sequences capture, table scan, drain and commit of one item.
module ldtu_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ldtu_pkg::ldtu_status_t status,
  output ldtu_pkg::ldtu_cmd_t    cmd
);
  import ldtu_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DRAIN,
    COMMIT
  } state_t;

  state_t state;
  logic [SLOT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          cnt <= '0;
          if (in_valid) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (cnt == SLOT_W'(TABLE_ENTRIES - 1)) begin
            state <= DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        DRAIN: begin
          state <= COMMIT;
        end
        COMMIT: begin
          if (!status.out_busy) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_comb begin
    in_stall = (state != IDLE);
    cmd.capture = (state == IDLE) && in_valid;
    cmd.rd_en = (state == SCAN);
    cmd.rd_addr = cnt;
    cmd.commit = (state == COMMIT) && !status.out_busy;
  end

endmodule

@@ src/ldtu_dp.sv @@
// Datapath: thresholds, table memories, scan compare and result register.
module ldtu_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ldtu_pkg::ldtu_cmd_t                     cmd,
  output ldtu_pkg::ldtu_status_t                  status,
  input  logic                                   cfg_write,
  input  logic [ldtu_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ldtu_pkg::SIG_W-1:0]              cfg_data,
  input  logic [ldtu_pkg::MAC_W-1:0]              mac_address,
  input  logic signed [ldtu_pkg::SIG_W-1:0]       signal_dbm,
  input  logic [ldtu_pkg::TICK_W-1:0]             tick_now,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [ldtu_pkg::MAC_W-1:0]              entry_mac,
  output logic signed [ldtu_pkg::SIG_W-1:0]       entry_signal_dbm,
  output logic [ldtu_pkg::CLASS_W-1:0]            strength_class,
  output logic [ldtu_pkg::SLOT_OUT_W-1:0]         slot_index,
  output logic                                   hit,
  output logic                                   replaced,
  output logic [ldtu_pkg::MAC_W-1:0]              replaced_mac,
  output logic [ldtu_pkg::COUNT_W-1:0]            replacement_count
);
  import ldtu_pkg::*;

  logic signed [SIG_W-1:0] strong_th;
  logic signed [SIG_W-1:0] moderate_th;
  logic signed [SIG_W-1:0] weak_th;

  logic [MAC_W-1:0] cur_mac;
  logic signed [SIG_W-1:0] cur_sig;
  logic [TICK_W-1:0] cur_tick;

  logic [MAC_W-1:0] mac_mem [TABLE_ENTRIES];
  logic [TICK_W-1:0] tick_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  logic rd_pend;
  logic rd_valid;
  logic [SLOT_W-1:0] rd_idx;
  logic [MAC_W-1:0] rd_mac;
  logic [TICK_W-1:0] rd_tick;

  logic hit_found;
  logic [SLOT_W-1:0] hit_slot;
  logic free_found;
  logic [SLOT_W-1:0] open_slot;
  logic lru_found;
  logic [SLOT_W-1:0] lru_slot;
  logic [TICK_W-1:0] lru_tick;
  logic [MAC_W-1:0] lru_mac;

  logic [COUNT_W-1:0] repl_count;
  logic [COUNT_W-1:0] repl_count_next;
  logic evict;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;

  assign status.out_busy = out_valid && out_stall;

  always_comb begin
    evict = !hit_found && !free_found;
    if (hit_found) begin
      slot = hit_slot;
    end else if (free_found) begin
      slot = open_slot;
    end else begin
      slot = lru_slot;
    end
    slot_wide = {{SLOT_OUT_W{1'b0}}, slot};
    repl_count_next = evict ? repl_count + 1'b1 : repl_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strong_th <= STRONG_RESET;
      moderate_th <= MODERATE_RESET;
      weak_th <= WEAK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_STRONG: strong_th <= cfg_data;
        CFG_MODERATE: moderate_th <= cfg_data;
        CFG_WEAK: weak_th <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_mac <= mac_address;
      cur_sig <= signal_dbm;
      cur_tick <= tick_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mac_mem[slot] <= cur_mac;
      tick_mem[slot] <= cur_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_mac <= mac_mem[cmd.rd_addr];
      rd_tick <= tick_mem[cmd.rd_addr];
      rd_valid <= valid[cmd.rd_addr];
      rd_idx <= cmd.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_pend <= 1'b0;
      repl_count <= '0;
    end else begin
      rd_pend <= cmd.rd_en;
      if (cmd.commit) begin
        valid[slot] <= 1'b1;
        repl_count <= repl_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found <= 1'b0;
      free_found <= 1'b0;
      lru_found <= 1'b0;
    end else if (cmd.capture) begin
      hit_found <= 1'b0;
      free_found <= 1'b0;
      lru_found <= 1'b0;
    end else if (rd_pend) begin
      if (rd_valid) begin
        if (rd_mac == cur_mac) begin
          if (!hit_found) begin
            hit_found <= 1'b1;
            hit_slot <= rd_idx;
          end
        end else if (!lru_found || rd_tick < lru_tick) begin
          lru_found <= 1'b1;
          lru_slot <= rd_idx;
          lru_tick <= rd_tick;
          lru_mac <= rd_mac;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        open_slot <= rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      entry_mac <= cur_mac;
      entry_signal_dbm <= cur_sig;
      strength_class <= classify(cur_sig, strong_th, moderate_th, weak_th);
      slot_index <= slot_wide[SLOT_OUT_W-1:0];
      hit <= hit_found;
      replaced <= evict;
      replaced_mac <= evict ? lru_mac : '0;
      replacement_count <= repl_count_next;
    end
  end

endmodule

@@ src/lru_device_table_upsert.sv @@
// Top level: device sighting table with least-recently-seen replacement.
// Each item is captured, then every slot is scanned, one slot per cycle, from the
// address and tick memories; no new item is taken until its result is committed,
// and commit waits while a result is held.
// Reset: all slots invalid, eviction count zero, thresholds -50/-70/-85 dBm.
// No clearing pass; items are accepted from the first cycle after reset.
module lru_device_table_upsert (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [ldtu_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ldtu_pkg::SIG_W-1:0]              cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [ldtu_pkg::MAC_W-1:0]              mac_address,
  input  logic signed [ldtu_pkg::SIG_W-1:0]       signal_dbm,
  input  logic [ldtu_pkg::TICK_W-1:0]             tick_now,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [ldtu_pkg::MAC_W-1:0]              entry_mac,
  output logic signed [ldtu_pkg::SIG_W-1:0]       entry_signal_dbm,
  output logic [ldtu_pkg::CLASS_W-1:0]            strength_class,
  output logic [ldtu_pkg::SLOT_OUT_W-1:0]         slot_index,
  output logic                                   hit,
  output logic                                   replaced,
  output logic [ldtu_pkg::MAC_W-1:0]              replaced_mac,
  output logic [ldtu_pkg::COUNT_W-1:0]            replacement_count
);
  import ldtu_pkg::*;

  ldtu_cmd_t cmd;
  ldtu_status_t status;

  ldtu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ldtu_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mac_address       (mac_address),
    .signal_dbm        (signal_dbm),
    .tick_now          (tick_now),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .entry_mac         (entry_mac),
    .entry_signal_dbm  (entry_signal_dbm),
    .strength_class    (strength_class),
    .slot_index        (slot_index),
    .hit               (hit),
    .replaced          (replaced),
    .replaced_mac      (replaced_mac),
    .replacement_count (replacement_count)
  );

endmodule

@@ test/tb_lru_device_table_upsert.sv @@
// Testbench for the device sighting table: directed and random sightings checked by a predictor.
module tb_lru_device_table_upsert;
  timeunit 1ns;
  timeprecision 1ps;
  import ldtu_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int RESULT_LATENCY = TABLE_ENTRIES + 3;
  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 4000;
  localparam int MAC_POOL_DEPTH = 48;

  typedef enum int {TICK_RISING, TICK_RANDOM, TICK_CLUSTERED, TICK_HIGH} tick_mode_t;

  typedef struct {
    logic [MAC_W-1:0] mac;
    logic [SIG_W-1:0] signal;
    logic [CLASS_W-1:0] strength;
    logic [SLOT_OUT_W-1:0] slot;
    logic was_hit;
    logic evicted;
    logic [MAC_W-1:0] evicted_mac;
    logic [COUNT_W-1:0] eviction_total;
  } entry_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [MAC_W-1:0] mac_address;
  logic signed [SIG_W-1:0] signal_dbm;
  logic [TICK_W-1:0] tick_now;
  logic out_valid;
  logic out_stall;
  logic [MAC_W-1:0] entry_mac;
  logic signed [SIG_W-1:0] entry_signal_dbm;
  logic [CLASS_W-1:0] strength_class;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic hit;
  logic replaced;
  logic [MAC_W-1:0] replaced_mac;
  logic [COUNT_W-1:0] replacement_count;

  bit tbl_valid [TABLE_ENTRIES];
  logic [MAC_W-1:0] tbl_mac [TABLE_ENTRIES];
  logic [TICK_W-1:0] tbl_tick [TABLE_ENTRIES];
  logic [COUNT_W-1:0] evictions;
  logic signed [SIG_W-1:0] th_strong;
  logic signed [SIG_W-1:0] th_moderate;
  logic signed [SIG_W-1:0] th_weak;

  entry_result_t expected_entries [$];
  entry_result_t head;
  logic [MAC_W-1:0] mac_pool [MAC_POOL_DEPTH];
  logic [TICK_W-1:0] tick_clock;
  bit calm;
  bit hold_request;
  int errors;
  int sent_count;
  int hit_total;
  int stuck_cycles;

  lru_device_table_upsert i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [CLASS_W-1:0] class_of(input logic signed [SIG_W-1:0] sig);
    return (sig >= th_strong) ? CLASS_STRONG :
           (sig >= th_moderate) ? CLASS_MODERATE :
           (sig >= th_weak) ? CLASS_WEAK : CLASS_VERY_WEAK;
  endfunction

  function automatic entry_result_t predict_upsert(input logic [MAC_W-1:0] mac,
                                                   input logic signed [SIG_W-1:0] sig,
                                                   input logic [TICK_W-1:0] tick);
    entry_result_t r;
    int open_slot;
    int oldest;
    int found;
    int slot;
    open_slot = -1;
    oldest = -1;
    found = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!tbl_valid[i]) begin
        if (open_slot < 0) open_slot = i;
      end else if (tbl_mac[i] == mac) begin
        found = i;
        break;
      end else if (oldest < 0 || tbl_tick[i] < tbl_tick[oldest]) begin
        oldest = i;
      end
    end
    r.was_hit = (found >= 0);
    r.evicted = 1'b0;
    r.evicted_mac = '0;
    if (found >= 0) begin
      slot = found;
      hit_total++;
    end else if (open_slot >= 0) begin
      slot = open_slot;
    end else begin
      slot = oldest;
      r.evicted = 1'b1;
      r.evicted_mac = tbl_mac[slot];
      evictions = evictions + 1'b1;
    end
    tbl_valid[slot] = 1'b1;
    tbl_mac[slot] = mac;
    tbl_tick[slot] = tick;
    r.mac = mac;
    r.signal = sig;
    r.strength = class_of(sig);
    r.slot = SLOT_OUT_W'(slot);
    r.eviction_total = evictions;
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    return MAC_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [MAC_W-1:0] pick_mac();
    int k;
    int roll;
    k = $urandom_range(0, MAC_POOL_DEPTH - 1);
    roll = $urandom_range(0, 19);
    if (roll < 2) begin
      mac_pool[k] = random_mac();
    end else if (roll == 2) begin
      mac_pool[k] = mac_pool[k] ^ (MAC_W'(1) << $urandom_range(0, MAC_W - 1));
    end
    return mac_pool[k];
  endfunction

  function automatic logic signed [SIG_W-1:0] pick_signal();
    logic signed [SIG_W-1:0] t;
    case ($urandom_range(0, 5))
      0: t = th_strong;
      1: t = th_moderate;
      2: t = th_weak;
      default: return SIG_W'($urandom());
    endcase
    return t - SIG_W'($urandom_range(0, 1));
  endfunction

  function automatic logic [TICK_W-1:0] next_tick(input tick_mode_t mode);
    case (mode)
      TICK_RISING: tick_clock = tick_clock + $urandom_range(0, 3);
      TICK_CLUSTERED: tick_clock = $urandom_range(0, 3);
      TICK_HIGH: tick_clock = 32'hFFFF_FFFF - $urandom_range(0, 7);
      default: tick_clock = $urandom();
    endcase
    return tick_clock;
  endfunction

  task automatic send_sighting(input logic [MAC_W-1:0] mac,
                               input logic signed [SIG_W-1:0] sig,
                               input logic [TICK_W-1:0] tick);
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mac_address <= mac;
    signal_dbm <= sig;
    tick_now <= tick;
    do @(posedge clk); while (in_stall);
    expected_entries.push_back(predict_upsert(mac, sig, tick));
    sent_count++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_entries.size() != 0) @(negedge clk);
    repeat (RESULT_LATENCY) @(negedge clk);
  endtask

  task automatic program_thresholds(input logic signed [SIG_W-1:0] s, m, w,
                                    input bit touch_unused);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_STRONG;
    cfg_data <= s;
    @(negedge clk);
    cfg_index <= CFG_MODERATE;
    cfg_data <= m;
    @(negedge clk);
    cfg_index <= CFG_WEAK;
    cfg_data <= w;
    @(negedge clk);
    if (touch_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_data <= SIG_W'($urandom());
      @(negedge clk);
    end
    cfg_write <= 1'b0;
    th_strong = s;
    th_moderate = m;
    th_weak = w;
    @(negedge clk);
  endtask

  task automatic run_sightings(input int count);
    tick_mode_t mode;
    mode = tick_mode_t'($urandom_range(0, 3));
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 49) == 0) mode = tick_mode_t'($urandom_range(0, 3));
      send_sighting(pick_mac(), pick_signal(), next_tick(mode));
    end
  endtask

  task automatic test_directed();
    send_sighting(48'h0, 8'sh80, 32'h0);
    send_sighting('1, 8'sd127, 32'hFFFF_FFFF);
    send_sighting(48'h0, -8'sd50, 32'd5);
    send_sighting(48'h0, -8'sd51, 32'd6);
    send_sighting(48'h0, -8'sd70, 32'd7);
    send_sighting(48'h0, -8'sd71, 32'd8);
    send_sighting(48'h0, -8'sd85, 32'd9);
    send_sighting(48'h0, -8'sd86, 32'd10);
    send_sighting('1, 8'sd0, 32'h0);
    send_sighting(48'h5555_5555_5555, 8'sh55, 32'h5555_5555);
    send_sighting(48'hAAAA_AAAA_AAAA, 8'shAA, 32'hAAAA_AAAA);
    send_sighting(48'h0000_0000_0001, -8'sd1, 32'h8000_0000);
    send_sighting(48'h8000_0000_0000, 8'sd1, 32'h7FFF_FFFF);
  endtask

  task automatic test_table_churn();
    calm = 1'b1;
    run_sightings(150);
    calm = 1'b0;
    run_sightings(450);
  endtask

  task automatic test_threshold_extremes();
    program_thresholds(8'sd127, 8'sd0, 8'sh80, 1'b0);
    run_sightings(100);
    program_thresholds(8'sh80, 8'sh80, 8'sh80, 1'b0);
    run_sightings(100);
    program_thresholds(8'sd127, 8'sd127, 8'sd127, 1'b1);
    run_sightings(100);
    program_thresholds(8'sh80, 8'sd127, 8'sd0, 1'b1);
    run_sightings(100);
  endtask

  task automatic test_output_holdoff();
    hold_request = 1'b1;
    run_sightings(40);
  endtask

  task automatic test_random_thresholds();
    repeat (4) begin
      program_thresholds(SIG_W'($urandom()), SIG_W'($urandom()), SIG_W'($urandom()),
                         bit'($urandom_range(0, 1)));
      run_sightings(170);
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 14);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_entries.size() == 0) begin
        $error("result for mac %h with no sighting pending", entry_mac);
        errors++;
      end else begin
        head = expected_entries.pop_front();
        if (entry_mac !== head.mac) begin
          $error("entry_mac: expected %h, got %h", head.mac, entry_mac);
          errors++;
        end
        if (entry_signal_dbm !== head.signal) begin
          $error("entry_signal_dbm: expected %0d, got %0d",
                 $signed(head.signal), entry_signal_dbm);
          errors++;
        end
        if (strength_class !== head.strength) begin
          $error("strength_class: expected %0d, got %0d", head.strength, strength_class);
          errors++;
        end
        if (slot_index !== head.slot) begin
          $error("slot_index: expected %0d, got %0d", head.slot, slot_index);
          errors++;
        end
        if (hit !== head.was_hit) begin
          $error("hit: expected %0b, got %0b", head.was_hit, hit);
          errors++;
        end
        if (replaced !== head.evicted) begin
          $error("replaced: expected %0b, got %0b", head.evicted, replaced);
          errors++;
        end
        if (replaced_mac !== head.evicted_mac) begin
          $error("replaced_mac: expected %h, got %h", head.evicted_mac, replaced_mac);
          errors++;
        end
        if (replacement_count !== head.eviction_total) begin
          $error("replacement_count: expected %0d, got %0d",
                 head.eviction_total, replacement_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("tb_lru_device_table_upsert failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_STRONG;
    cfg_data = '0;
    in_valid = 1'b0;
    mac_address = '0;
    signal_dbm = '0;
    tick_now = '0;
    calm = 1'b0;
    hold_request = 1'b0;
    tick_clock = '0;
    errors = 0;
    sent_count = 0;
    hit_total = 0;
    stuck_cycles = 0;
    evictions = '0;
    th_strong = STRONG_RESET;
    th_moderate = MODERATE_RESET;
    th_weak = WEAK_RESET;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_mac[i] = '0;
      tbl_tick[i] = '0;
    end
    for (int i = 0; i < MAC_POOL_DEPTH; i++) mac_pool[i] = random_mac();
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_table_churn();
    test_threshold_extremes();
    test_output_holdoff();
    test_random_thresholds();
    wait_idle();
    $display("Covered %0d sightings: %0d table hits, %0d evictions of the oldest entry,",
             sent_count, hit_total, evictions);
    $display("under nine threshold settings with both extremes and one long output hold-off.");
    if (errors == 0) begin
      $display("tb_lru_device_table_upsert passed");
    end else begin
      $display("tb_lru_device_table_upsert failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/ldtu_pkg.sv
src/ldtu_ctrl.sv
src/ldtu_dp.sv
src/lru_device_table_upsert.sv
test/tb_lru_device_table_upsert.sv
